// ----- rtl/core/rrspan_pkg.sv -----
// Shared types and constants for the rounded rectangle row span generator.
package rrspan_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_RECT_LEFT     = 3'd0,
        CFG_RECT_TOP      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_CORNER_MASK   = 3'd5
    } t_cfg_idx;

    // Corner mask bits
    localparam logic [3:0] MASK_TL = 4'h1;
    localparam logic [3:0] MASK_TR = 4'h2;
    localparam logic [3:0] MASK_BL = 4'h4;
    localparam logic [3:0] MASK_BR = 4'h8;

    // One root digit per step; radius is at most 11 bits
    localparam int ROOT_STEPS = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQUARE,
        ST_DIFF,
        ST_ROOT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic square;
        logic diff;
        logic root_step;
        logic finish;
    } t_ctrl_cmd;

endpackage

// ----- rtl/core/rrspan_ctrl.sv -----
// Sequencer for the row span datapath: steps one row through its phases.
module rrspan_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_ready,
    output logic                  o_valid,
    output rrspan_pkg::t_ctrl_cmd o_cmd
);
    import rrspan_pkg::*;

    localparam int StepW = $clog2(ROOT_STEPS);

    t_state           r_state, n_state;
    logic [StepW-1:0] r_step, n_step;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_step     = '0;
                n_state    = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == StepW'(ROOT_STEPS - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- rtl/core/rrspan_dp.sv -----
// Datapath: configuration registers, corner setup, square root and span clip.
module rrspan_dp #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rrspan_pkg::t_ctrl_cmd i_cmd,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [12:0]           i_cfg_data,
    input  logic [11:0]           i_row_offset,
    output logic signed [13:0]    o_screen_row,
    output logic [11:0]           o_span_start,
    output logic [12:0]           o_span_end,
    output logic                  o_span_visible
);
    import rrspan_pkg::*;

    localparam logic signed [13:0] ScreenW = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] ScreenH = 14'(SCREEN_HEIGHT);

    // configuration
    logic signed [12:0] r_left, r_top;
    logic [11:0]        r_width, r_height;
    logic [10:0]        r_radius;
    logic [3:0]         r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_radius <= '0;
            r_mask   <= MASK_TL | MASK_TR | MASK_BL | MASK_BR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RECT_LEFT:     r_left   <= i_cfg_data;
                CFG_RECT_TOP:      r_top    <= i_cfg_data;
                CFG_RECT_WIDTH:    r_width  <= i_cfg_data[11:0];
                CFG_RECT_HEIGHT:   r_height <= i_cfg_data[11:0];
                CFG_CORNER_RADIUS: r_radius <= i_cfg_data[10:0];
                CFG_CORNER_MASK:   r_mask   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // working registers
    logic [11:0]        r_row;
    logic signed [13:0] r_ay;
    logic               r_base_vis;
    logic [10:0]        r_r, r_dy;
    logic               r_cut_l, r_cut_r;
    logic [21:0]        r_rsq, r_dsq, r_v;
    logic [11:0]        r_rem;
    logic [10:0]        r_root;

    // setup: screen row, basic visibility, clamped radius and corner distance
    logic signed [13:0] w_ay;
    logic               w_base_vis, w_round;
    logic [10:0]        w_r, w_dy;
    logic [11:0]        w_h_minus_r;
    logic               w_top, w_bot, w_cut_l, w_cut_r;

    assign w_ay = $signed({r_top[12], r_top}) + $signed({2'b00, r_row});
    assign w_base_vis = (r_width != '0) && (r_height != '0) && (r_row < r_height)
                        && !w_ay[13] && (w_ay < ScreenH);
    assign w_round = w_base_vis && (r_radius != '0) && (r_mask != '0);

    always_comb begin
        w_r = r_radius;
        if (w_r > r_width[11:1]) begin
            w_r = r_width[11:1];
        end
        if (w_r > r_height[11:1]) begin
            w_r = r_height[11:1];
        end
    end

    assign w_h_minus_r = r_height - {1'b0, w_r};
    assign w_top = r_row < {1'b0, w_r};
    assign w_bot = r_row >= w_h_minus_r;

    always_comb begin
        w_dy    = '0;
        w_cut_l = 1'b0;
        w_cut_r = 1'b0;
        priority if (w_top) begin
            w_dy    = 11'({1'b0, w_r} - r_row - 12'd1);
            w_cut_l = w_round && ((r_mask & MASK_TL) != '0);
            w_cut_r = w_round && ((r_mask & MASK_TR) != '0);
        end else if (w_bot) begin
            w_dy    = 11'(r_row - w_h_minus_r);
            w_cut_l = w_round && ((r_mask & MASK_BL) != '0);
            w_cut_r = w_round && ((r_mask & MASK_BR) != '0);
        end else begin
            w_dy = '0;
        end
    end

    // root step: two radicand bits per step, remainder kept below 2*root+1
    logic [13:0] w_rem_sh, w_trial;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_v[21:20]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    // finish: cut, edges, clip
    logic [11:0]        w_ceil;
    logic [10:0]        w_cut, w_cut_lv, w_cut_rv;
    logic signed [13:0] w_x0, w_x1, w_x0c, w_x1c;
    logic               w_vis;

    assign w_ceil   = {1'b0, r_root} + {11'b0, (r_rem != '0)};
    assign w_cut    = 11'({1'b0, r_r} - w_ceil);
    assign w_cut_lv = r_cut_l ? w_cut : 11'd0;
    assign w_cut_rv = r_cut_r ? w_cut : 11'd0;
    assign w_x0 = $signed({r_left[12], r_left}) + $signed({3'b000, w_cut_lv});
    assign w_x1 = $signed({r_left[12], r_left}) + $signed({2'b00, r_width})
                  - $signed({3'b000, w_cut_rv});
    assign w_x0c = w_x0[13] ? 14'sd0 : w_x0;
    assign w_x1c = (w_x1 > ScreenW) ? ScreenW : w_x1;
    assign w_vis = r_base_vis && (w_x0c < w_x1c);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_row <= i_row_offset;
        end
        if (i_cmd.prep) begin
            r_ay       <= w_ay;
            r_base_vis <= w_base_vis;
            r_r        <= w_r;
            r_dy       <= w_dy;
            r_cut_l    <= w_cut_l;
            r_cut_r    <= w_cut_r;
        end
        if (i_cmd.square) begin
            r_rsq <= {11'b0, r_r} * {11'b0, r_r};
            r_dsq <= {11'b0, r_dy} * {11'b0, r_dy};
        end
        if (i_cmd.diff) begin
            r_v    <= r_rsq - r_dsq;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root_step) begin
            r_v <= {r_v[19:0], 2'b00};
            if (w_ge) begin
                r_rem  <= 12'(w_rem_sh - w_trial);
                r_root <= {r_root[9:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[11:0];
                r_root <= {r_root[9:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            o_screen_row   <= r_ay;
            o_span_start   <= w_vis ? w_x0c[11:0] : 12'd0;
            o_span_end     <= w_vis ? w_x1c[12:0] : 13'd0;
            o_span_visible <= w_vis;
        end
    end

endmodule

// ----- rtl/core/rounded_rect_row_span.sv -----
// Rows are taken one at a time: a new row is accepted only once the last has reached the output register.
// Each row runs an 11-step digit-by-digit square root.
// The output register frees the input side: a new row is taken while a result waits.
// Reset (i_rst_n low, synchronous): sequencer idle, no result pending,
// geometry registers zero and all four corners marked rounded.
module rounded_rect_row_span #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // row offset beats
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [11:0]        i_row_offset,
    // span beats
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [13:0] o_screen_row,
    output logic [11:0]        o_span_start,
    output logic [12:0]        o_span_end,
    output logic               o_span_visible,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data
);
    import rrspan_pkg::*;

    t_ctrl_cmd w_cmd;

    // Registers take a write in any cycle; writes land only while idle by contract.
    assign o_cfg_ready = 1'b1;

    // Sequencer: accept a row, then step setup, squares, difference,
    // eleven root digits and the final clip into the output register.
    rrspan_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    // Datapath: clamp the radius, find the corner row distance, compute
    // ceil(sqrt(r*r - dy*dy)), cut the rounded sides and clip to the screen.
    rrspan_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_row_offset   (i_row_offset),
        .o_screen_row   (o_screen_row),
        .o_span_start   (o_span_start),
        .o_span_end     (o_span_end),
        .o_span_visible (o_span_visible)
    );

`ifndef ASSERT_OFF
    // An invisible span reports zero edges.
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_span_visible) |-> (o_span_start == '0 && o_span_end == '0))
        else $error("invisible span with nonzero edges");

    // A visible span is nonempty and ends on screen.
    a_vis_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_span_visible) |->
            ({1'b0, o_span_start} < o_span_end && o_span_end <= 13'(SCREEN_WIDTH)))
        else $error("visible span out of order or off screen");

    // Never overwrite a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_valid || i_ready))
        else $error("result overwritten while stalled");

    // One row in flight: after an accepted beat the input side closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second row accepted while one is in flight");
`endif

endmodule

// ----- sim/rounded_rect_row_span_tb.sv -----
// Self-checking testbench for the rounded rectangle row span generator.
`timescale 1ns / 1ps

module rounded_rect_row_span_tb;
    import rrspan_pkg::*;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 768;
    // Generous bound: about 1850 rows, plus gaps and stalls
    localparam int CYCLE_LIMIT = 400_000;
    // Register indexes past the end of the register map; writes there change nothing
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [13:0] screen_row;
        logic [11:0]        span_start;
        logic [12:0]        span_end;
        logic               span_visible;
    } t_row_span;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [11:0]        i_row_offset = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [13:0] o_screen_row;
    logic [11:0]        o_span_start;
    logic [12:0]        o_span_end;
    logic               o_span_visible;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [12:0]        i_cfg_data = '0;

    // Shadow copy of the geometry registers, at their reset values
    logic signed [12:0] geo_left = '0;
    logic signed [12:0] geo_top = '0;
    logic [11:0]        geo_width = '0;
    logic [11:0]        geo_height = '0;
    logic [10:0]        geo_radius = '0;
    logic [3:0]         geo_mask = 4'hf;

    t_row_span expected_spans[$];
    t_row_span want_span;
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        quiet_stretch = 1'b0;

    rounded_rect_row_span #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_row_offset  (i_row_offset),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_screen_row  (o_screen_row),
        .o_span_start  (o_span_start),
        .o_span_end    (o_span_end),
        .o_span_visible(o_span_visible),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d spans outstanding", $time, expected_spans.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the span side about 6 percent of the time, except in the quiet stretch
    always @(posedge i_clk) begin
        i_ready <= quiet_stretch || ($urandom_range(0, 99) >= 6);
    end

    // Smallest s with s*s >= v, by bisection over the radius range
    function automatic int root_ceil(input int v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 2048;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (mid * mid >= v) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    // Corner radius after clamping to half the width and half the height
    function automatic int clamped_radius();
        int r;
        r = geo_radius;
        if (r > geo_width / 2) r = geo_width / 2;
        if (r > geo_height / 2) r = geo_height / 2;
        return r;
    endfunction

    // Work out the span of one row from the shadow registers
    function automatic t_row_span predict_row_span(input logic [11:0] row_off);
        t_row_span res;
        int row;
        int ay;
        int w;
        int h;
        int x0;
        int x1;
        int r;
        int dy;
        int cut;
        logic [3:0] lbit;
        logic [3:0] rbit;
        bit vis;
        row = row_off;
        ay = int'(geo_top) + row;
        w = geo_width;
        h = geo_height;
        x0 = int'(geo_left);
        x1 = int'(geo_left) + w;
        vis = 1'b1;
        lbit = '0;
        rbit = '0;
        if (w == 0 || h == 0 || row >= h) vis = 1'b0;
        if (ay < 0 || ay >= SCREEN_H) vis = 1'b0;
        if (vis && geo_radius != 0 && geo_mask != 0) begin
            r = clamped_radius();
            dy = -1;
            // Top corner rows count dy up toward the top edge, bottom rows down
            if (row < r) begin
                dy = r - row - 1;
                lbit = MASK_TL;
                rbit = MASK_TR;
            end else if (row >= h - r) begin
                dy = row - (h - r);
                lbit = MASK_BL;
                rbit = MASK_BR;
            end
            if (dy >= 0) begin
                cut = r - root_ceil(r * r - dy * dy);
                if ((geo_mask & lbit) != 0) x0 = x0 + cut;
                if ((geo_mask & rbit) != 0) x1 = x1 - cut;
            end
        end
        if (x0 < 0) x0 = 0;
        if (x1 > SCREEN_W) x1 = SCREEN_W;
        if (x0 >= x1) vis = 1'b0;
        res.screen_row = 14'(ay);
        res.span_start = vis ? 12'(x0) : '0;
        res.span_end = vis ? 13'(x1) : '0;
        res.span_visible = vis;
        return res;
    endfunction

    // Mostly a value in the typical range, now and then one of the two extremes
    function automatic int pick_value(input int lo, input int hi, input int typ_lo,
                                      input int typ_hi);
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            default: return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
        endcase
    endfunction

    // Favor rows inside the rectangle, and within it the rounded corners
    function automatic logic [11:0] pick_row();
        int h;
        int rc;
        h = geo_height;
        rc = clamped_radius();
        if (h == 0) return 12'($urandom);
        case ($urandom_range(0, 9))
            0, 1: return 12'($urandom);
            2, 3, 4: return 12'($urandom_range(0, h - 1));
            5, 6: return 12'($urandom_range(0, rc));
            default: return 12'(h - 1 - int'($urandom_range(0, rc)));
        endcase
    endfunction

    // Write one register; leave valid high so back-to-back writes need no toggle
    task automatic cfg_write(input logic [2:0] idx, input logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RECT_LEFT:     geo_left = data;
            CFG_RECT_TOP:      geo_top = data;
            CFG_RECT_WIDTH:    geo_width = data[11:0];
            CFG_RECT_HEIGHT:   geo_height = data[11:0];
            CFG_CORNER_RADIUS: geo_radius = data[10:0];
            CFG_CORNER_MASK:   geo_mask = data[3:0];
            default: ;
        endcase
    endtask

    // Send one row beat and record its span; valid stays high afterward
    task automatic send_row(input logic [11:0] row);
        if (!quiet_stretch && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_row_offset <= row;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_spans.push_back(predict_row_span(row));
    endtask

    // Drop valid and hold until every outstanding span has come back
    task automatic drain_spans();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_spans.size() != 0);
    endtask

    task automatic write_geometry(input int left, input int top, input int width,
                                  input int height, input int radius, input int mask);
        cfg_write(CFG_RECT_LEFT, 13'(left));
        cfg_write(CFG_RECT_TOP, 13'(top));
        cfg_write(CFG_RECT_WIDTH, 13'(width));
        cfg_write(CFG_RECT_HEIGHT, 13'(height));
        cfg_write(CFG_CORNER_RADIUS, 13'(radius));
        cfg_write(CFG_CORNER_MASK, 13'(mask));
        i_cfg_valid <= 1'b0;
    endtask

    // Empty rectangle out of reset, then the default all-corners mask
    task automatic test_reset_state();
        send_row(12'd0);
        send_row(12'hfff);
        drain_spans();
        cfg_write(CFG_RECT_WIDTH, 13'd200);
        cfg_write(CFG_RECT_HEIGHT, 13'd100);
        cfg_write(CFG_CORNER_RADIUS, 13'd20);
        i_cfg_valid <= 1'b0;
        send_row(12'd0);
        send_row(12'd50);
        send_row(12'd99);
        drain_spans();
    endtask

    // Huge plain rectangle: clipping on the left and right, rows leaving the screen
    task automatic test_plain_rect();
        write_geometry(-3000, -10, 4095, 4095, 0, 15);
        send_row(12'd9);
        send_row(12'd10);
        send_row(12'd777);
        send_row(12'd778);
        send_row(12'hfff);
        drain_spans();
    endtask

    // No corners at all, then one rounded corner at a time with the radius clamped
    task automatic test_corner_mask();
        logic [3:0] corner_bits [4];
        corner_bits = '{MASK_TL, MASK_TR, MASK_BL, MASK_BR};
        write_geometry(100, 50, 300, 200, 2047, 0);
        send_row(12'd0);
        foreach (corner_bits[k]) begin
            drain_spans();
            cfg_write(CFG_CORNER_MASK, 13'(corner_bits[k]));
            i_cfg_valid <= 1'b0;
            send_row(12'd0);
            send_row(12'd199);
        end
        drain_spans();
        // Smallest radius: the corner row loses nothing
        cfg_write(CFG_CORNER_RADIUS, 13'd1);
        cfg_write(CFG_CORNER_MASK, 13'(MASK_TL | MASK_TR | MASK_BL | MASK_BR));
        i_cfg_valid <= 1'b0;
        send_row(12'd0);
        drain_spans();
    endtask

    // Right screen edge, a span that starts past it, and the corner coordinates
    task automatic test_screen_edges();
        write_geometry(1020, 767, 8, 4, 2, 15);
        send_row(12'd0);
        send_row(12'd1);
        drain_spans();
        cfg_write(CFG_RECT_LEFT, 13'd1024);
        i_cfg_valid <= 1'b0;
        send_row(12'd0);
        drain_spans();
        cfg_write(CFG_RECT_LEFT, 13'd4095);
        cfg_write(CFG_RECT_TOP, 13'(-4096));
        i_cfg_valid <= 1'b0;
        send_row(12'd0);
        drain_spans();
    endtask

    // Writes to unmapped indexes must leave the geometry alone
    task automatic test_spare_index();
        write_geometry(10, 10, 64, 64, 16, 15);
        cfg_write(CFG_SPARE_LO, 13'h1fff);
        cfg_write(CFG_SPARE_HI, 13'h0000);
        i_cfg_valid <= 1'b0;
        send_row(12'd0);
        send_row(12'd63);
        drain_spans();
    endtask

    // Random geometry per phase, a burst of rows against each
    task automatic test_random_rows();
        for (int ph = 0; ph < 30; ph++) begin
            quiet_stretch = (ph >= 12 && ph < 16);
            drain_spans();
            if ($urandom_range(0, 7) == 0) begin
                // Raw noise in every register, spare indexes included
                for (int k = 0; k <= CFG_SPARE_HI; k++) cfg_write(3'(k), 13'($urandom));
                i_cfg_valid <= 1'b0;
            end else begin
                write_geometry(pick_value(-4096, 4095, -100, 1100),
                               pick_value(-4096, 4095, -80, 820),
                               pick_value(0, 4095, 1, ($urandom_range(0, 3) == 0) ? 4095 : 600),
                               pick_value(0, 4095, 1, ($urandom_range(0, 3) == 0) ? 4095 : 400),
                               pick_value(0, 2047, 0, ($urandom_range(0, 1) == 0) ? 2047 : 80),
                               $urandom_range(0, 15));
            end
            for (int n = 0; n < 61; n++) begin
                // Hold the sender once mid-phase until the pipeline runs dry
                if (ph == 5 && n == 30) drain_spans();
                send_row(pick_row());
            end
        end
        quiet_stretch = 1'b0;
        drain_spans();
    endtask

    // Compare each span beat against the oldest outstanding prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_spans.size() == 0) begin
                $display("%0t: span beat with none expected: row %0d [%0d,%0d) vis %0b",
                         $time, o_screen_row, o_span_start, o_span_end, o_span_visible);
                fail_count++;
            end else begin
                want_span = expected_spans.pop_front();
                if (o_screen_row !== want_span.screen_row) begin
                    $display("%0t: screen_row expected %0d got %0d",
                             $time, want_span.screen_row, o_screen_row);
                    fail_count++;
                end
                if (o_span_start !== want_span.span_start) begin
                    $display("%0t: span_start expected %0d got %0d",
                             $time, want_span.span_start, o_span_start);
                    fail_count++;
                end
                if (o_span_end !== want_span.span_end) begin
                    $display("%0t: span_end expected %0d got %0d",
                             $time, want_span.span_end, o_span_end);
                    fail_count++;
                end
                if (o_span_visible !== want_span.span_visible) begin
                    $display("%0t: span_visible expected %0b got %0b",
                             $time, want_span.span_visible, o_span_visible);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_plain_rect();
        test_corner_mask();
        test_screen_edges();
        test_spare_index();
        test_random_rows();
        // Give any stray beat time to show up after the last expected one
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
